// ----- rtl/der_tlv_header_parser_macros.svh -----
// Assertion macros for the DER TLV header parser.
`ifndef DER_TLV_HEADER_PARSER_MACROS_SVH
`define DER_TLV_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DTLV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DTLV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dertlv_pkg.sv -----
// Shared types and constants for the DER TLV header parser.
`timescale 1ns / 1ps

package dertlv_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN_FIRST,
        PH_LEN_LONG,
        PH_CONTENT
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_TAG,
        ST_BAD_FORM,
        ST_ZERO_LEN,
        ST_INT_LONG,
        ST_OVER_LIMIT
    } t_status;

    typedef struct packed {
        logic    fail;
        t_status status;
    } t_len_chk;

    localparam logic [1:0]  KIND_SEQ      = 2'd0;
    localparam logic [1:0]  KIND_BITSTR   = 2'd1;
    localparam logic [1:0]  KIND_INT      = 2'd2;

    localparam logic [7:0]  TAG_SEQ       = 8'h30;
    localparam logic [7:0]  TAG_BITSTR    = 8'h03;
    localparam logic [7:0]  TAG_INT       = 8'h02;

    localparam logic [7:0]  LEN_LONG_BIT  = 8'h80;
    localparam logic [7:0]  LEN_CNT_MASK  = 8'h7f;

    localparam logic [15:0] MAX_INT_LEN_RST = 16'd16384;

    // Expected tag for a kind; bit 8 set means no tag can match.
    function automatic logic [8:0] tag_for_kind(input logic [1:0] kind);
        logic [8:0] tag;
        case (kind)
            KIND_SEQ:    tag = {1'b0, TAG_SEQ};
            KIND_BITSTR: tag = {1'b0, TAG_BITSTR};
            KIND_INT:    tag = {1'b0, TAG_INT};
            default:     tag = 9'h100;
        endcase
        return tag;
    endfunction

    function automatic logic [31:0] sat_dec(input logic [31:0] v);
        return (v != 32'd0) ? v - 32'd1 : 32'd0;
    endfunction

endpackage

// ----- rtl/dertlv_len_check.sv -----
// Checks a decoded content length against zero and, for INTEGER, against the limit and the buffer.
`timescale 1ns / 1ps

module dertlv_len_check (
    input  logic [31:0]           i_len,
    input  logic [1:0]            i_kind,
    input  logic [31:0]           i_buf_left,
    input  logic [15:0]           i_max_int_len,
    output dertlv_pkg::t_len_chk  o_chk
);
    import dertlv_pkg::*;

    always_comb begin
        o_chk.fail   = 1'b0;
        o_chk.status = ST_OK;
        if (i_len == 32'd0) begin
            o_chk.fail   = 1'b1;
            o_chk.status = ST_ZERO_LEN;
        end else if (i_kind == KIND_INT &&
                     (i_len > i_buf_left || i_len > {16'd0, i_max_int_len})) begin
            o_chk.fail   = 1'b1;
            o_chk.status = ST_INT_LONG;
        end
    end

endmodule

// ----- rtl/der_tlv_header_parser.sv -----
// DER TLV header parser: tag check, length decode and content pass-through.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_data_byte, i_start_req, i_object_kind,
//                                            i_bytes_available
//   result    out        o_valid / i_ready   o_out_byte, o_out_valid, o_last, o_status,
//                                            o_object_length
//   config    in         i_cfg_we            i_cfg_wdata (max_integer_length)
//
// One word per cycle while o_ready is high: each word updates the parse state and the result
// register in the same cycle, so results appear in the cycle after the word is taken.
// o_ready drops only while a result sits in the output register and i_ready is low.
// Synchronous active-low reset returns the parser to idle and the limit to 16384.
// Header words give a result only when they end in an error; a dropped leading zero of an
// INTEGER gives one only when it ends the object.
`timescale 1ns / 1ps

module der_tlv_header_parser #(
    parameter int LEN_BYTES_MAX = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_req,
    input  logic [1:0]  i_object_kind,
    input  logic [31:0] i_bytes_available,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_last,
    output logic [2:0]  o_status,
    output logic [31:0] o_object_length
);
    import dertlv_pkg::*;

    `include "der_tlv_header_parser_macros.svh"

    localparam int LBW = $clog2(LEN_BYTES_MAX + 1);

    // parse state
    logic [15:0]    r_max_int_len;
    t_phase         r_phase,        n_phase;
    logic [1:0]     r_kind,         n_kind;
    logic [31:0]    r_content_left, n_content_left;
    logic [LBW-1:0] r_len_left,     n_len_left;
    logic           r_first,        n_first;
    logic [31:0]    r_buf_left,     n_buf_left;
    logic [31:0]    r_obj_len,      n_obj_len;

    // result register
    logic           r_res_valid,    n_res_valid;
    logic [7:0]     r_out_byte,     n_out_byte;
    logic           r_out_valid,    n_out_valid;
    logic           r_last,         n_last;
    t_status        r_status,       n_status;
    logic [31:0]    r_res_len,      n_res_len;

    logic           in_acc;
    logic [31:0]    buf_dec;
    logic [31:0]    len_cand;
    logic [31:0]    long_acc;
    logic [6:0]     len_cnt;
    logic [LBW-1:0] len_left_dec;
    logic [31:0]    cl_dec;
    logic           drop;
    t_len_chk       chk;

    assign o_ready = !r_res_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    assign buf_dec      = sat_dec(r_buf_left);
    assign long_acc     = {r_content_left[23:0], i_data_byte};
    assign len_cnt      = i_data_byte[6:0] & LEN_CNT_MASK[6:0];
    assign len_left_dec = (r_len_left != '0) ? r_len_left - LBW'(1) : '0;
    assign cl_dec       = sat_dec(r_content_left);
    assign drop         = r_kind == KIND_INT && r_first && i_data_byte == 8'd0;
    assign len_cand     = (r_phase == PH_LEN_LONG) ? long_acc : {24'd0, i_data_byte};

    dertlv_len_check u_len_check (
        .i_len         (len_cand),
        .i_kind        (r_kind),
        .i_buf_left    (buf_dec),
        .i_max_int_len (r_max_int_len),
        .o_chk         (chk)
    );

    always_comb begin
        n_phase        = r_phase;
        n_kind         = r_kind;
        n_content_left = r_content_left;
        n_len_left     = r_len_left;
        n_first        = r_first;
        n_buf_left     = r_buf_left;
        n_obj_len      = r_obj_len;

        n_res_valid    = r_res_valid && !i_ready;
        n_out_byte     = r_out_byte;
        n_out_valid    = r_out_valid;
        n_last         = r_last;
        n_status       = r_status;
        n_res_len      = r_res_len;
        if (o_ready) begin
            n_out_byte  = 8'd0;
            n_out_valid = 1'b0;
            n_last      = 1'b0;
            n_status    = ST_OK;
            n_res_len   = 32'd0;
        end

        if (in_acc) begin
            if (i_start_req) begin
                n_kind         = i_object_kind;
                n_buf_left     = sat_dec(i_bytes_available);
                n_content_left = 32'd0;
                n_len_left     = '0;
                n_first        = 1'b0;
                n_obj_len      = 32'd0;
                if ({1'b0, i_data_byte} != tag_for_kind(i_object_kind)) begin
                    n_phase     = PH_IDLE;
                    n_res_valid = 1'b1;
                    n_last      = 1'b1;
                    n_status    = ST_BAD_TAG;
                end else begin
                    n_phase = PH_LEN_FIRST;
                end
            end else begin
                case (r_phase)
                    PH_LEN_FIRST: begin
                        n_buf_left = buf_dec;
                        if ((i_data_byte & LEN_LONG_BIT) != 8'd0) begin
                            if (len_cnt == 7'd0) begin
                                n_phase     = PH_IDLE;
                                n_res_valid = 1'b1;
                                n_last      = 1'b1;
                                n_status    = ST_BAD_FORM;
                            end else if (len_cnt > 7'(LEN_BYTES_MAX)) begin
                                n_phase     = PH_IDLE;
                                n_res_valid = 1'b1;
                                n_last      = 1'b1;
                                n_status    = ST_OVER_LIMIT;
                            end else begin
                                n_content_left = 32'd0;
                                n_len_left     = LBW'(len_cnt);
                                n_phase        = PH_LEN_LONG;
                            end
                        end else if (chk.fail) begin
                            n_phase     = PH_IDLE;
                            n_res_valid = 1'b1;
                            n_last      = 1'b1;
                            n_status    = chk.status;
                            n_res_len   = (chk.status == ST_INT_LONG) ? len_cand : 32'd0;
                        end else begin
                            n_content_left = len_cand;
                            n_obj_len      = len_cand;
                            n_first        = 1'b1;
                            n_phase        = PH_CONTENT;
                        end
                    end
                    PH_LEN_LONG: begin
                        n_buf_left = buf_dec;
                        if (r_content_left[31:24] != 8'd0) begin
                            // length would not fit in 32 bits
                            n_phase     = PH_IDLE;
                            n_res_valid = 1'b1;
                            n_last      = 1'b1;
                            n_status    = ST_OVER_LIMIT;
                        end else begin
                            n_content_left = long_acc;
                            n_len_left     = len_left_dec;
                            if (len_left_dec == '0) begin
                                if (chk.fail) begin
                                    n_phase     = PH_IDLE;
                                    n_res_valid = 1'b1;
                                    n_last      = 1'b1;
                                    n_status    = chk.status;
                                    n_res_len   = (chk.status == ST_INT_LONG) ?
                                                  len_cand : 32'd0;
                                end else begin
                                    n_obj_len = len_cand;
                                    n_first   = 1'b1;
                                    n_phase   = PH_CONTENT;
                                end
                            end
                        end
                    end
                    PH_CONTENT: begin
                        n_buf_left     = buf_dec;
                        n_first        = 1'b0;
                        n_content_left = cl_dec;
                        if (drop) begin
                            n_obj_len = sat_dec(r_obj_len);
                        end
                        if (cl_dec == 32'd0) begin
                            n_phase     = PH_IDLE;
                            n_res_valid = 1'b1;
                            n_last      = 1'b1;
                            n_res_len   = drop ? sat_dec(r_obj_len) : r_obj_len;
                            if (!drop) begin
                                n_out_byte  = i_data_byte;
                                n_out_valid = 1'b1;
                            end
                        end else if (!drop) begin
                            n_res_valid = 1'b1;
                            n_out_byte  = i_data_byte;
                            n_out_valid = 1'b1;
                        end
                    end
                    default: begin
                        // idle: stray word, nothing to do
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_int_len  <= MAX_INT_LEN_RST;
            r_phase        <= PH_IDLE;
            r_kind         <= KIND_SEQ;
            r_content_left <= 32'd0;
            r_len_left     <= '0;
            r_first        <= 1'b0;
            r_buf_left     <= 32'd0;
            r_obj_len      <= 32'd0;
            r_res_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_int_len <= i_cfg_wdata;
            end
            r_phase        <= n_phase;
            r_kind         <= n_kind;
            r_content_left <= n_content_left;
            r_len_left     <= n_len_left;
            r_first        <= n_first;
            r_buf_left     <= n_buf_left;
            r_obj_len      <= n_obj_len;
            r_res_valid    <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_valid <= n_out_valid;
        r_last      <= n_last;
        r_status    <= n_status;
        r_res_len   <= n_res_len;
    end

    assign o_valid         = r_res_valid;
    assign o_out_byte      = r_out_byte;
    assign o_out_valid     = r_out_valid;
    assign o_last          = r_last;
    assign o_status        = r_status;
    assign o_object_length = r_res_len;

    `DTLV_ASSERT_NOW(a_err_is_last,
        o_valid && o_status != ST_OK,
        o_last && !o_out_valid,
        "error result without last or with data")
    `DTLV_ASSERT_NOW(a_mid_is_data,
        o_valid && !o_last,
        o_out_valid && o_status == ST_OK && o_object_length == 32'd0,
        "non-last result is not a plain data word")
    `DTLV_ASSERT_NOW(a_content_nonzero,
        r_phase == PH_CONTENT,
        r_content_left != 32'd0,
        "content phase with nothing left")
    `DTLV_ASSERT_NEXT(a_idle_silent,
        in_acc && !i_start_req && r_phase == PH_IDLE,
        !o_valid,
        "stray word while idle gave a result")

endmodule

// ----- tb/tb_der_tlv_header_parser.sv -----
// Self-checking testbench for der_tlv_header_parser: directed, stall and random DER streams.
`timescale 1ns / 1ps

module tb_der_tlv_header_parser;
    import dertlv_pkg::*;

    localparam int         LEN_MAX      = 4;
    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         IDLE_PCT     = 37;
    localparam int         WORDS_PER_SET = 110;
    localparam logic [1:0] KIND_NONE    = 2'd3;   // kind with no tag

    typedef struct packed {
        logic [7:0]  data;
        logic        data_ok;
        logic        last;
        logic [2:0]  status;
        logic [31:0] obj_len;
    } t_parsed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = MAX_INT_LEN_RST;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_start_req = 1'b0;
    logic [1:0]  i_object_kind = KIND_SEQ;
    logic [31:0] i_bytes_available = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_out_valid;
    logic        o_last;
    logic [2:0]  o_status;
    logic [31:0] o_object_length;

    der_tlv_header_parser #(
        .LEN_BYTES_MAX(LEN_MAX)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_start_req      (i_start_req),
        .i_object_kind    (i_object_kind),
        .i_bytes_available(i_bytes_available),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_out_valid      (o_out_valid),
        .o_last           (o_last),
        .o_status         (o_status),
        .o_object_length  (o_object_length)
    );

    always #2 i_clk = ~i_clk;

    // Parser model state
    t_phase      parse_phase = PH_IDLE;
    logic [1:0]  kind_q = '0;
    logic [31:0] content_left = '0;
    logic [3:0]  len_left = '0;
    logic        first_q = 1'b0;
    logic [31:0] buf_left = '0;
    logic [31:0] obj_len = '0;
    logic [15:0] int_limit = MAX_INT_LEN_RST;

    t_parsed     parsed_due[$];
    int          n_errors = 0;
    int          n_words = 0;
    int          n_cycles = 0;
    int          hold_left = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    function automatic void take_buffer_byte();
        if (buf_left != 0) buf_left = buf_left - 1;
    endfunction

    function automatic bit end_with_error(input logic [2:0] st, input logic [31:0] len,
                                          output t_parsed r);
        parse_phase = PH_IDLE;
        r = '0;
        r.last = 1'b1;
        r.status = st;
        r.obj_len = len;
        return 1'b1;
    endfunction

    function automatic bit accept_length(input logic [31:0] len, output t_parsed r);
        r = '0;
        if (len == 0) return end_with_error(ST_ZERO_LEN, 32'd0, r);
        if (kind_q == KIND_INT && (len > buf_left || len > int_limit))
            return end_with_error(ST_INT_LONG, len, r);
        content_left = len;
        obj_len = len;
        first_q = 1'b1;
        parse_phase = PH_CONTENT;
        return 1'b0;
    endfunction

    // Advances the model by one word; returns 1 when the word yields a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                      input logic [1:0] kind, input logic [31:0] avail,
                                      output t_parsed r);
        logic       tag_ok;
        logic       drop;
        logic       is_last;
        logic [7:0] n;
        r = '0;
        if (start) begin
            kind_q = kind;
            buf_left = avail;
            take_buffer_byte();
            content_left = '0;
            len_left = '0;
            first_q = 1'b0;
            obj_len = '0;
            case (kind)
                KIND_SEQ:    tag_ok = (b == TAG_SEQ);
                KIND_BITSTR: tag_ok = (b == TAG_BITSTR);
                KIND_INT:    tag_ok = (b == TAG_INT);
                default:     tag_ok = 1'b0;
            endcase
            if (!tag_ok) return end_with_error(ST_BAD_TAG, 32'd0, r);
            parse_phase = PH_LEN_FIRST;
            return 1'b0;
        end
        case (parse_phase)
            PH_LEN_FIRST: begin
                take_buffer_byte();
                if ((b & LEN_LONG_BIT) != 0) begin
                    n = b & LEN_CNT_MASK;
                    if (n == 0) return end_with_error(ST_BAD_FORM, 32'd0, r);
                    if (n > LEN_MAX) return end_with_error(ST_OVER_LIMIT, 32'd0, r);
                    content_left = '0;
                    len_left = n[3:0];
                    parse_phase = PH_LEN_LONG;
                    return 1'b0;
                end
                return accept_length({24'd0, b}, r);
            end
            PH_LEN_LONG: begin
                take_buffer_byte();
                if (content_left[31:24] != 0) return end_with_error(ST_OVER_LIMIT, 32'd0, r);
                content_left = {content_left[23:0], b};
                if (len_left != 0) len_left = len_left - 4'd1;
                if (len_left == 0) return accept_length(content_left, r);
                return 1'b0;
            end
            PH_CONTENT: begin
                // a leading zero of an INTEGER is swallowed
                drop = (kind_q == KIND_INT && first_q && b == 8'd0);
                take_buffer_byte();
                first_q = 1'b0;
                if (content_left != 0) content_left = content_left - 1;
                is_last = (content_left == 0);
                if (drop && obj_len != 0) obj_len = obj_len - 1;
                if (is_last) parse_phase = PH_IDLE;
                if (drop) begin
                    if (!is_last) return 1'b0;
                    r.last = 1'b1;
                    r.status = ST_OK;
                    r.obj_len = obj_len;
                    return 1'b1;
                end
                r.data = b;
                r.data_ok = 1'b1;
                r.last = is_last;
                r.status = ST_OK;
                r.obj_len = is_last ? obj_len : 32'd0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] tag_of(input logic [1:0] kind);
        case (kind)
            KIND_SEQ:    return TAG_SEQ;
            KIND_BITSTR: return TAG_BITSTR;
            default:     return TAG_INT;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start, input logic [1:0] kind,
                             input logic [31:0] avail);
        t_parsed r;
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_start_req <= start;
        i_object_kind <= kind;
        i_bytes_available <= avail;
        do @(posedge i_clk); while (!o_ready);
        if (start || parse_phase != PH_IDLE) n_words++;
        if (parse_byte(b, start, kind, avail, r)) parsed_due.push_back(r);
        if (!tx_steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // Tag, length (short form when nlen is 0), then nbody content words.
    task automatic send_tlv(input logic [1:0] kind, input int len, input int nlen,
                            input logic [31:0] avail, input bit zero_first, input int nbody);
        int k;
        send_byte(tag_of(kind), 1'b1, kind, avail);
        if (nlen == 0) begin
            send_byte(len[7:0], 1'b0, 2'($urandom_range(3)), $urandom);
        end else begin
            send_byte(LEN_LONG_BIT | 8'(nlen), 1'b0, 2'($urandom_range(3)), $urandom);
            for (k = nlen - 1; k >= 0; k--)
                send_byte(8'(len >> (8 * k)), 1'b0, 2'($urandom_range(3)), $urandom);
        end
        for (k = 0; k < nbody; k++)
            send_byte((k == 0 && zero_first) ? 8'd0 : 8'($urandom_range(255)), 1'b0,
                      2'($urandom_range(3)), $urandom);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (parsed_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_int_limit(input logic [15:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        int_limit = v;
    endtask

    task automatic send_random_object();
        int          r;
        int          len;
        int          nlen;
        int          need;
        int          hdr;
        logic [1:0]  kind;
        logic [31:0] avail;
        kind = 2'($urandom_range(2));
        if ($urandom_range(99) < 80) begin
            r = $urandom_range(99);
            len = (r < 70) ? $urandom_range(1, 6) :
                  (r < 95) ? $urandom_range(7, 40) : $urandom_range(128, 300);
            need = (len < 128) ? 0 : (len < 256) ? 1 : 2;
            if (need != 0) nlen = $urandom_range(need, LEN_MAX);
            else nlen = ($urandom_range(3) == 0) ? $urandom_range(1, LEN_MAX) : 0;
            hdr = 2 + nlen;
            r = $urandom_range(99);
            avail = (r < 75) ? 32'(hdr + len + $urandom_range(20)) :
                    (r < 85) ? 32'(hdr + len - 1) :
                    (r < 90) ? 32'(hdr + len) : $urandom;
            send_tlv(kind, len, nlen, avail, ($urandom_range(2) == 0), len);
        end else begin
            case ($urandom_range(4))
                0: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                             2'($urandom_range(3)), $urandom);
                1: begin
                    // long form with a zero count or a count beyond the maximum
                    send_byte(tag_of(kind), 1'b1, kind, $urandom);
                    send_byte(LEN_LONG_BIT | (($urandom_range(1) == 0) ? 8'd0 :
                              8'($urandom_range(LEN_MAX + 1, 127))), 1'b0, kind, $urandom);
                end
                2: send_tlv(kind, 0, $urandom_range(0, LEN_MAX), $urandom, 1'b0, 0);
                3: begin
                    // cut short; the next start abandons it
                    len = $urandom_range(2, 10);
                    send_tlv(kind, len, 0, $urandom_range(100, 1000), 1'b0,
                             $urandom_range(0, len - 1));
                end
                default: send_byte(tag_of(kind) ^ (8'd1 << $urandom_range(7)), 1'b1, kind,
                                   $urandom);
            endcase
        end
    endtask

    task automatic test_directed();
        send_byte(8'hff, 1'b0, KIND_SEQ, 32'd0);                 // idle word, ignored
        send_tlv(KIND_SEQ, 1, 2, 32'd0, 1'b0, 1);                // buffer count saturates
        send_byte(TAG_SEQ, 1'b1, KIND_BITSTR, 32'd7);            // wrong tag
        send_byte(TAG_INT, 1'b1, KIND_NONE, 32'hffff_ffff);      // kind without a tag
        send_byte(TAG_INT, 1'b1, KIND_INT, 32'd100);
        send_byte(LEN_LONG_BIT, 1'b0, KIND_INT, 32'd0);          // long form, zero count
        send_byte(TAG_BITSTR, 1'b1, KIND_BITSTR, 32'd100);
        send_byte(LEN_LONG_BIT | 8'(LEN_MAX + 1), 1'b0, KIND_SEQ, 32'd0);
        send_tlv(KIND_BITSTR, 0, 0, 32'd10, 1'b0, 0);            // zero length
        send_tlv(KIND_INT, 2, 0, 32'd3, 1'b0, 0);                // longer than the buffer
        send_tlv(KIND_INT, 2, 0, 32'hffff_ffff, 1'b1, 2);        // leading zero dropped
        send_tlv(KIND_INT, 1, 0, 32'd3, 1'b1, 1);                // only a zero
        send_tlv(KIND_SEQ, 5, 1, 32'd50, 1'b0, 1);               // abandoned by next start
        send_tlv(KIND_INT, 1, 0, 32'd10, 1'b0, 1);
        wait_drained();
    endtask

    // Output held off long enough that the parser must stall its input.
    task automatic test_backpressure();
        hold_left <= 80;
        tx_steady = 1'b1;
        send_tlv(KIND_SEQ, 40, 1, $urandom, 1'b0, 40);
        tx_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_pause();
        int k;
        for (k = 0; k < 12; k++) begin
            send_random_object();
            wait_drained();
        end
    endtask

    task automatic test_random();
        logic [15:0] limits [4];
        int          p;
        int          goal;
        limits = '{16'd1, 16'($urandom_range(2, 8)), 16'hffff, MAX_INT_LEN_RST};
        for (p = 0; p < 4; p++) begin
            set_int_limit(limits[p]);
            // one set runs with no idling on either side
            tx_steady = (p == 2);
            rx_steady = (p == 2);
            goal = n_words + WORDS_PER_SET;
            while (n_words < goal) send_random_object();
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (rx_steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %h actual %h", $time, what, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_parsed want;
        if (i_rst_n && o_valid && i_ready) begin
            if (parsed_due.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h %b %b %0d %h", $time,
                         o_out_byte, o_out_valid, o_last, o_status, o_object_length);
                n_errors++;
            end else begin
                want = parsed_due.pop_front();
                check_field("out_byte", 32'(want.data), 32'(o_out_byte));
                check_field("out_valid", 32'(want.data_ok), 32'(o_out_valid));
                check_field("last", 32'(want.last), 32'(o_last));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("object_length", want.obj_len, o_object_length);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("der_tlv_header_parser: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_pause();
        test_random();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("der_tlv_header_parser: match");
        else
            $display("der_tlv_header_parser: mismatch");
        $finish;
    end

endmodule

// ----- der_tlv_header_parser.f -----
+incdir+rtl
rtl/dertlv_pkg.sv
rtl/dertlv_len_check.sv
rtl/der_tlv_header_parser.sv
tb/tb_der_tlv_header_parser.sv
